/* hdl/mandel_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandel_pkg
// Shared types, constants, microprogram and arithmetic helpers for the
// Mandelbrot escape-time unit.
// ----------------------------------------------------------------------------
package mandel_pkg;

	// fixed point format and word widths
	localparam int WORD_W    = 32;
	localparam int STEP_W_B  = 31;
	localparam int ITER_W    = 16;
	localparam int PIX_W     = 10;
	localparam int MUL_W     = 33;
	localparam int PROD_W    = 64;
	localparam int FRAC_BITS = 28;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_RE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IM  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = CFG_IDX_W'(3);

	// register reset values
	localparam logic signed [WORD_W-1:0] ORIGIN_RE_RST  = -32'sd536870912;
	localparam logic signed [WORD_W-1:0] ORIGIN_IM_RST  = -32'sd402653184;
	localparam logic [STEP_W_B-1:0]      PIXEL_STEP_RST = 31'd786432;
	localparam logic [ITER_W-1:0]        ITER_LIMIT_RST = 16'd256;

	// saturation limits and escape radius squared (4.0)
	localparam logic signed [PROD_W-1:0] WORD_MAX_L = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [PROD_W-1:0] WORD_MIN_L = 64'shFFFF_FFFF_8000_0000;
	localparam logic [PROD_W-1:0]        ESC_BOUND  = 64'd4 << FRAC_BITS;

	// microprogram step addresses
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_FETCH     = 3'd0;
	localparam logic [STEP_W-1:0] STEP_MUL_PIXEL = 3'd1;
	localparam logic [STEP_W-1:0] STEP_FORM_C    = 3'd2;
	localparam logic [STEP_W-1:0] STEP_MUL_ORBIT = 3'd3;
	localparam logic [STEP_W-1:0] STEP_ITERATE   = 3'd4;
	localparam logic [STEP_W-1:0] STEP_EMIT      = 3'd5;

	typedef enum logic [1:0] {
		MUL_IDLE,
		MUL_PIXEL,
		MUL_ORBIT
	} mul_op_t;

	typedef enum logic [1:0] {
		ALU_IDLE,
		ALU_FORM_C,
		ALU_ITERATE
	} alu_op_t;

	typedef enum logic [2:0] {
		BR_NEXT,
		BR_JUMP,
		BR_WAIT_IN,
		BR_LOOP,
		BR_WAIT_OUT
	} br_t;

	// one control word of the microprogram
	typedef struct packed {
		mul_op_t           mul_op;
		alu_op_t           alu_op;
		br_t               br;
		logic [STEP_W-1:0] target;
	} ucode_t;

	// branch conditions seen by the sequencer
	typedef struct packed {
		logic in_fire;
		logic out_free;
		logic stop;
	} seq_cond_t;

	// control store
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_t w;
		case (step)
			STEP_FETCH:     w = '{MUL_IDLE,  ALU_IDLE,    BR_WAIT_IN,  STEP_MUL_PIXEL};
			STEP_MUL_PIXEL: w = '{MUL_PIXEL, ALU_IDLE,    BR_NEXT,     STEP_FORM_C};
			STEP_FORM_C:    w = '{MUL_IDLE,  ALU_FORM_C,  BR_NEXT,     STEP_MUL_ORBIT};
			STEP_MUL_ORBIT: w = '{MUL_ORBIT, ALU_IDLE,    BR_NEXT,     STEP_ITERATE};
			STEP_ITERATE:   w = '{MUL_IDLE,  ALU_ITERATE, BR_LOOP,     STEP_MUL_ORBIT};
			STEP_EMIT:      w = '{MUL_IDLE,  ALU_IDLE,    BR_WAIT_OUT, STEP_FETCH};
			default:        w = '{MUL_IDLE,  ALU_IDLE,    BR_JUMP,     STEP_FETCH};
		endcase
		return w;
	endfunction

	// clamp a wide signed value to the signed word range
	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
		logic signed [WORD_W-1:0] r;
		if (v > WORD_MAX_L) begin
			r = WORD_MAX_L[WORD_W-1:0];
		end else if (v < WORD_MIN_L) begin
			r = WORD_MIN_L[WORD_W-1:0];
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

/* hdl/mandelbrot_escape_time.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time
// Escape-time unit: forms c from a pixel position and iterates z = z^2 + c
// in signed Q4.28 until |z|^2 >= 4 or the iteration limit is reached.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   ----------------------------------
//  in        in_valid / in_ready    pixel_col, pixel_row
//  out       out_valid / out_ready  iteration_count, escaped
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// From request to result, an item with count n takes one multiply step and
// one update step per iteration through the three multipliers, plus pixel
// multiply, point forming, the final multiply and escape test, and result load.
// A new request can be taken in the cycle after the result loads into the output
// register, which holds it while out_ready is low; a second result waits in
// the sequencer until that register is free. Reset restores the register
// defaults and returns the sequencer to the fetch step.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [mandel_pkg::PIX_W-1:0]           pixel_col,
	input  logic [mandel_pkg::PIX_W-1:0]           pixel_row,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [mandel_pkg::ITER_W-1:0]          iteration_count,
	output logic                                   escaped,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mandel_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mandel_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import mandel_pkg::*;

	logic signed [WORD_W-1:0] origin_re_q, origin_im_q;
	logic [STEP_W_B-1:0]      pixel_step_q;
	logic [ITER_W-1:0]        limit_q;

	ucode_t                   ctrl;
	seq_cond_t                cond;
	logic [STEP_W-1:0]        step;
	logic                     in_fire, out_fire, load_out, stop;
	logic [ITER_W-1:0]        dp_count;
	logic                     dp_escaped;

	logic                     out_valid_q;
	logic [ITER_W-1:0]        count_q;
	logic                     escaped_q;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_re_q  <= ORIGIN_RE_RST;
			origin_im_q  <= ORIGIN_IM_RST;
			pixel_step_q <= PIXEL_STEP_RST;
			limit_q      <= ITER_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ORIGIN_RE:  origin_re_q  <= $signed(cfg_data[WORD_W-1:0]);
				CFG_ORIGIN_IM:  origin_im_q  <= $signed(cfg_data[WORD_W-1:0]);
				CFG_PIXEL_STEP: pixel_step_q <= cfg_data[STEP_W_B-1:0];
				CFG_ITER_LIMIT: limit_q      <= cfg_data[ITER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// handshakes
	assign in_ready = (ctrl.br == BR_WAIT_IN);
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid_q && out_ready;
	assign load_out = (ctrl.br == BR_WAIT_OUT) && cond.out_free;

	assign cond.in_fire  = in_fire;
	assign cond.out_free = !out_valid_q || out_ready;
	assign cond.stop     = stop;

	// sequencer
	mandel_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cond   (cond),
		.ctrl   (ctrl),
		.step   (step)
	);

	// datapath
	mandel_dp u_dp (
		.clk             (clk),
		.ctrl            (ctrl),
		.in_fire         (in_fire),
		.pixel_col       (pixel_col),
		.pixel_row       (pixel_row),
		.origin_re       (origin_re_q),
		.origin_im       (origin_im_q),
		.pixel_step      (pixel_step_q),
		.iteration_limit (limit_q),
		.stop            (stop),
		.count           (dp_count),
		.escaped         (dp_escaped)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			count_q   <= dp_count;
			escaped_q <= dp_escaped;
		end
	end

	assign out_valid       = out_valid_q;
	assign iteration_count = count_q;
	assign escaped         = escaped_q;

	// a request starts the program and leaves the fetch step
	a_fetch_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (!in_ready && step == STEP_MUL_PIXEL))
		else $error("sequencer did not start after request");

	// the iteration counter never passes the limit while iterating
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(step == STEP_ITERATE) |-> (dp_count <= limit_q))
		else $error("iteration counter beyond limit");

	// a non-escaped result always ran to the limit
	a_inside_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !escaped_q) |-> (count_q == limit_q))
		else $error("inside result below limit");

	// a result is only loaded from the emit step
	a_load_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(step) == STEP_EMIT))
		else $error("result loaded outside emit step");

endmodule

/* hdl/mandel_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandel_seq
// Microcode sequencer: step counter, control store lookup and branching.
// ----------------------------------------------------------------------------
module mandel_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mandel_pkg::seq_cond_t cond,
	output mandel_pkg::ucode_t    ctrl,
	output logic [mandel_pkg::STEP_W-1:0] step
);
	import mandel_pkg::*;

	logic [STEP_W-1:0] pc_q;
	logic [STEP_W-1:0] pc_next;

	// current control word
	assign ctrl = ucode_rom(pc_q);
	assign step = pc_q;

	// next step selection
	always_comb begin
		case (ctrl.br)
			BR_NEXT:     pc_next = STEP_W'(pc_q + 1'b1);
			BR_JUMP:     pc_next = ctrl.target;
			BR_WAIT_IN:  pc_next = cond.in_fire ? ctrl.target : pc_q;
			BR_LOOP:     pc_next = cond.stop ? STEP_W'(pc_q + 1'b1) : ctrl.target;
			BR_WAIT_OUT: pc_next = cond.out_free ? ctrl.target : pc_q;
			default:     pc_next = STEP_FETCH;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_FETCH;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule

/* hdl/mandel_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandel_dp
// Datapath: three registered multipliers, point forming, escape test and
// orbit update with saturation, iteration counter.
// ----------------------------------------------------------------------------
module mandel_dp (
	input  logic                                 clk,
	input  mandel_pkg::ucode_t                   ctrl,
	input  logic                                 in_fire,
	input  logic [mandel_pkg::PIX_W-1:0]         pixel_col,
	input  logic [mandel_pkg::PIX_W-1:0]         pixel_row,
	input  logic signed [mandel_pkg::WORD_W-1:0] origin_re,
	input  logic signed [mandel_pkg::WORD_W-1:0] origin_im,
	input  logic [mandel_pkg::STEP_W_B-1:0]      pixel_step,
	input  logic [mandel_pkg::ITER_W-1:0]        iteration_limit,
	output logic                                 stop,
	output logic [mandel_pkg::ITER_W-1:0]        count,
	output logic                                 escaped
);
	import mandel_pkg::*;

	logic [PIX_W-1:0]           col_q, row_q;
	logic signed [WORD_W-1:0]   c_re_q, c_im_q, x_q, y_q;
	logic [ITER_W-1:0]          iter_q;
	logic                       esc_q;

	logic signed [MUL_W-1:0]    op_a_l, op_a_r, op_b_l, op_b_r, op_x, op_y;
	logic signed [2*MUL_W-1:0]  full_a, full_b, full_c;
	logic signed [PROD_W-1:0]   prod_a_q, prod_b_q, prod_c_q;

	logic signed [PROD_W-1:0]   sq_re, sq_im, xy_prod, clip_re, clip_im;
	logic signed [PROD_W-1:0]   c_re_wide, c_im_wide, nx_wide, ny_wide;
	logic [PROD_W-1:0]          disk_sum;
	logic                       out_of_disk;

	// capture pixel position on request
	always_ff @(posedge clk) begin
		if (in_fire) begin
			col_q <= pixel_col;
			row_q <= pixel_row;
		end
	end

	// multiplier operand selection
	always_comb begin
		op_x = {x_q[WORD_W-1], x_q};
		op_y = {y_q[WORD_W-1], y_q};
		case (ctrl.mul_op)
			MUL_PIXEL: begin
				op_a_l = $signed({2'b00, pixel_step});
				op_a_r = $signed({(MUL_W-PIX_W)'(0), col_q});
				op_b_l = $signed({2'b00, pixel_step});
				op_b_r = $signed({(MUL_W-PIX_W)'(0), row_q});
			end
			default: begin
				op_a_l = op_x;
				op_a_r = op_x;
				op_b_l = op_y;
				op_b_r = op_y;
			end
		endcase
	end

	assign full_a = op_a_l * op_a_r;
	assign full_b = op_b_l * op_b_r;
	assign full_c = op_x * op_y;

	// product registers
	always_ff @(posedge clk) begin
		if (ctrl.mul_op != MUL_IDLE) begin
			prod_a_q <= full_a[PROD_W-1:0];
			prod_b_q <= full_b[PROD_W-1:0];
			prod_c_q <= full_c[PROD_W-1:0];
		end
	end

	// scaled products, floor rounding
	assign sq_re   = prod_a_q >>> FRAC_BITS;
	assign sq_im   = prod_b_q >>> FRAC_BITS;
	assign xy_prod = prod_c_q >>> FRAC_BITS;

	// escape test on the unsaturated squares
	assign disk_sum    = PROD_W'($unsigned(sq_re) + $unsigned(sq_im));
	assign out_of_disk = (disk_sum >= ESC_BOUND);
	assign stop        = out_of_disk || (iter_q >= iteration_limit);

	// orbit update terms
	assign clip_re   = (sq_re > WORD_MAX_L) ? WORD_MAX_L : sq_re;
	assign clip_im   = (sq_im > WORD_MAX_L) ? WORD_MAX_L : sq_im;
	assign nx_wide   = clip_re - clip_im + PROD_W'(c_re_q);
	assign ny_wide   = (xy_prod <<< 1) + PROD_W'(c_im_q);

	// point forming from the pixel products
	assign c_re_wide = PROD_W'(origin_re) + prod_a_q;
	assign c_im_wide = PROD_W'(origin_im) + prod_b_q;

	// orbit and counter registers
	always_ff @(posedge clk) begin
		case (ctrl.alu_op)
			ALU_FORM_C: begin
				c_re_q <= sat_word(c_re_wide);
				c_im_q <= sat_word(c_im_wide);
				x_q    <= sat_word(c_re_wide);
				y_q    <= sat_word(c_im_wide);
				iter_q <= '0;
			end
			ALU_ITERATE: begin
				if (stop) begin
					esc_q <= out_of_disk;
				end else begin
					x_q    <= sat_word(nx_wide);
					y_q    <= sat_word(ny_wide);
					iter_q <= ITER_W'(iter_q + 1'b1);
				end
			end
			default: begin
			end
		endcase
	end

	assign count   = iter_q;
	assign escaped = esc_q;

endmodule
